// ===== rtl/utrd_pkg.sv =====
// ----------------------------------------------------------------------------
// utrd_pkg
// Shared types, constants and the digit-to-character lookup for the
// unsigned-to-radix-digits block.
// ----------------------------------------------------------------------------
package utrd_pkg;

   localparam int RADIX_W = 6;
   localparam int DIGIT_W = 6;
   localparam int CHAR_W  = 8;

   localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_A_BASE = 8'h57;   // 'a' minus ten
   localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'h00;
   localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 6'd10;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic div_step;
      logic digit_write;
      logic ptr_dec;
      logic load_digit;
      logic load_err;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic radix_ok;
      logic div_last;
      logic quot_zero;
      logic ptr_zero;
      logic out_free;
   } status_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] digit);
      logic [CHAR_W-1:0] wide;
      wide = {{(CHAR_W-DIGIT_W){1'b0}}, digit};
      if (digit < DECIMAL_LIMIT) begin
         digit_to_char = CHAR_ZERO + wide;
      end else begin
         digit_to_char = CHAR_A_BASE + wide;
      end
   endfunction

endpackage

// ===== rtl/utrd_ram.sv =====
// ----------------------------------------------------------------------------
// utrd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module utrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/utrd_datapath.sv =====
// ----------------------------------------------------------------------------
// utrd_datapath
// Radix register, shift-subtract divider (one quotient bit per cycle),
// digit buffer and the result output register.
// ----------------------------------------------------------------------------
module utrd_datapath #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  utrd_pkg::cmd_type                   cmd,
   output utrd_pkg::status_type                status,
   input  logic [VALUE_WIDTH-1:0]              req_value,
   input  logic                                csr_write_en,
   input  logic [utrd_pkg::RADIX_W-1:0]        csr_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [utrd_pkg::CHAR_W-1:0]         rsp_digit_char,
   output logic                                rsp_last,
   output logic                                rsp_error
);

   localparam int PTR_W = $clog2(VALUE_WIDTH);
   localparam logic [PTR_W-1:0] BIT_LAST = PTR_W'(VALUE_WIDTH - 1);

   logic [utrd_pkg::RADIX_W-1:0] radix_ff, radix_in;
   logic [utrd_pkg::RADIX_W-1:0] base;
   logic [VALUE_WIDTH-1:0]       quot_ff, quot_in;
   logic [utrd_pkg::DIGIT_W-1:0] rem_ff, rem_in;
   logic [PTR_W-1:0]             bit_ff, bit_in;
   logic [PTR_W-1:0]             ptr_ff, ptr_in;
   logic [utrd_pkg::DIGIT_W:0]   trial;
   logic                         trial_ge;
   logic [utrd_pkg::DIGIT_W-1:0] ram_rd_data;
   logic                         out_valid_ff, out_valid_in;
   logic [utrd_pkg::CHAR_W-1:0]  out_char_ff, out_char_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_error_ff, out_error_in;
   logic                         out_free;

   assign base = (radix_ff == '0) ? utrd_pkg::RADIX_DEFAULT : radix_ff;

   // partial remainder shifted left with the next dividend bit
   assign trial    = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign trial_ge = trial >= {1'b0, base};

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      radix_in = csr_write_en ? csr_write_data : radix_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      bit_in   = bit_ff;
      ptr_in   = ptr_ff;
      if (cmd.start) begin
         quot_in = req_value;
         rem_in  = '0;
         bit_in  = '0;
         ptr_in  = '0;
      end else if (cmd.div_step) begin
         quot_in = {quot_ff[VALUE_WIDTH-2:0], trial_ge};
         rem_in  = trial_ge ? utrd_pkg::DIGIT_W'(trial - {1'b0, base})
                            : trial[utrd_pkg::DIGIT_W-1:0];
         bit_in  = bit_ff + 1'b1;
      end else if (cmd.digit_write) begin
         rem_in = '0;
         bit_in = '0;
         if (quot_ff != '0) begin
            ptr_in = ptr_ff + 1'b1;
         end
      end else if (cmd.ptr_dec) begin
         ptr_in = ptr_ff - 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_error_in = out_error_ff;
      if (cmd.load_digit) begin
         out_valid_in = 1'b1;
         out_char_in  = utrd_pkg::digit_to_char(ram_rd_data);
         out_last_in  = (ptr_ff == '0);
         out_error_in = 1'b0;
      end else if (cmd.load_err) begin
         out_valid_in = 1'b1;
         out_char_in  = utrd_pkg::CHAR_NONE;
         out_last_in  = 1'b1;
         out_error_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= utrd_pkg::RADIX_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         radix_ff     <= radix_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      bit_ff       <= bit_in;
      ptr_ff       <= ptr_in;
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      out_error_ff <= out_error_in;
   end

   // digits land least significant first and are read back from the top
   utrd_ram #(
      .WIDTH (utrd_pkg::DIGIT_W),
      .DEPTH (VALUE_WIDTH)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (cmd.digit_write),
      .wr_addr (ptr_ff),
      .wr_data (rem_ff),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign status.radix_ok  = (base >= utrd_pkg::RADIX_MIN) && (base <= utrd_pkg::RADIX_MAX);
   assign status.div_last  = (bit_ff == BIT_LAST);
   assign status.quot_zero = (quot_ff == '0);
   assign status.ptr_zero  = (ptr_ff == '0);
   assign status.out_free  = out_free;

   assign rsp_valid      = out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_error      = out_error_ff;

endmodule

// ===== rtl/utrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// utrd_ctrl
// Sequencer: accepts a value, runs one division per digit, then plays the
// stored digits back most significant first.
// ----------------------------------------------------------------------------
module utrd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  utrd_pkg::status_type status,
   output utrd_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_WRITE = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_LOAD  = 3'd4;
   localparam logic [2:0] S_ERR   = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.radix_ok) begin
                  cmd.start = 1'b1;
                  state_in  = S_DIV;
               end else begin
                  state_in = S_ERR;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            cmd.digit_write = 1'b1;
            state_in = status.quot_zero ? S_READ : S_DIV;
         end
         S_READ: begin
            // ram read data is registered, so it is ready in S_LOAD
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (status.out_free) begin
               cmd.load_digit = 1'b1;
               if (status.ptr_zero) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.ptr_dec = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         S_ERR: begin
            if (status.out_free) begin
               cmd.load_err = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/unsigned_to_radix_digits.sv =====
// Each digit takes one full division of the remaining quotient; the stored
// digits are then played out, most significant first, one beat at a time.
// Throughput: one value at a time; the restoring divider (one quotient bit per
// cycle) sets the pace. An invalid radix gives a single error beat.
// Reset (synchronous, active high) sets the radix to 10 and empties the output.
// ----------------------------------------------------------------------------
// unsigned_to_radix_digits
// Converts an unsigned value to lower-case ASCII digits in a configurable
// radix, most significant digit first, with last on the final beat.
// ----------------------------------------------------------------------------
module unsigned_to_radix_digits #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [VALUE_WIDTH-1:0]        req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [utrd_pkg::CHAR_W-1:0]   rsp_digit_char,
   output logic                          rsp_last,
   output logic                          rsp_error,
   input  logic                          csr_write_en,
   input  logic [utrd_pkg::RADIX_W-1:0]  csr_write_data
);

   utrd_pkg::cmd_type    cmd;
   utrd_pkg::status_type status;

   utrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   utrd_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_value),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error)
   );

`ifndef SYNTHESIS
   // busy right after taking a value
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted beat");

   a_error_beat_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && (rsp_digit_char == utrd_pkg::CHAR_NONE))
      else $error("error beat without last or with a nonzero character");

   a_digit_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |->
         ((rsp_digit_char >= 8'h30) && (rsp_digit_char <= 8'h39)) ||
         ((rsp_digit_char >= 8'h61) && (rsp_digit_char <= 8'h7a)))
      else $error("digit beat carries a character outside 0-9 and a-z");
`endif

endmodule
